/* rtl/rcss_pkg.sv */
// rcss_pkg: shared types, codes and constants of the radio channel setup sequencer
// used by rcss_front, rcss_cmdq, rcss_back, the top level and the checker
package rcss_pkg;

   // defaults of the top level parameters
   localparam int ACK_QUEUE_LIMIT_DEF      = 4;
   localparam int SEARCH_TIMEOUT_VALUE_DEF = 10;

   // decoded request queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // field widths
   localparam int KIND_W    = 3;
   localparam int EVENT_W   = 4;
   localparam int RID_W     = 3;
   localparam int DEVICE_W  = 16;
   localparam int PAYLOAD_W = 64;
   localparam int CMD_W     = 4;
   localparam int CHAN_W    = 3;
   localparam int CTYPE_W   = 8;
   localparam int STATE_W   = 4;
   localparam int NOTICE_W  = 2;
   localparam int PERIOD_W  = 16;
   localparam int TICKS_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int OP_W      = 4;

   // register reset values
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET      = 16'd8192;
   localparam logic [TICKS_W-1:0]   ACK_TIMEOUT_RESET = 16'd1000;
   localparam logic [PAYLOAD_W-1:0] MASTER_CHAN_TYPE  = 64'h10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_NUMBER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESET_DEVICE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_TYPE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MASTER_MODE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ACK_TIMEOUT_TICKS = 3'd5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_START     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EVENT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BROADCAST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ID_FOUND  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUEUE_ACK = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd6;

   // channel event codes
   localparam logic [EVENT_W-1:0] EV_OK             = 4'd0;
   localparam logic [EVENT_W-1:0] EV_SEARCH_TIMEOUT = 4'd1;
   localparam logic [EVENT_W-1:0] EV_GO_SEARCH      = 4'd3;
   localparam logic [EVENT_W-1:0] EV_CLOSED         = 4'd4;
   localparam logic [EVENT_W-1:0] EV_ACK_DONE       = 4'd6;
   localparam logic [EVENT_W-1:0] EV_ACK_FAIL       = 4'd7;

   // response ids
   localparam logic [RID_W-1:0] RID_ASSIGN   = 3'd0;
   localparam logic [RID_W-1:0] RID_ID       = 3'd1;
   localparam logic [RID_W-1:0] RID_FREQ     = 3'd2;
   localparam logic [RID_W-1:0] RID_PERIOD   = 3'd3;
   localparam logic [RID_W-1:0] RID_TIMEOUT  = 3'd4;
   localparam logic [RID_W-1:0] RID_OPEN     = 3'd5;
   localparam logic [RID_W-1:0] RID_CLOSE    = 3'd6;
   localparam logic [RID_W-1:0] RID_UNASSIGN = 3'd7;

   // commands
   localparam logic [CMD_W-1:0] CMD_NONE         = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ASSIGN       = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SET_ID       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_FREQ         = 4'd3;
   localparam logic [CMD_W-1:0] CMD_PERIOD       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SEARCH_TO    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_OPEN         = 4'd6;
   localparam logic [CMD_W-1:0] CMD_CLOSE        = 4'd7;
   localparam logic [CMD_W-1:0] CMD_UNASSIGN     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_REQUEST_ID   = 4'd9;
   localparam logic [CMD_W-1:0] CMD_INFINITE_TO  = 4'd10;
   localparam logic [CMD_W-1:0] CMD_SEND_ACK     = 4'd11;

   // channel states
   localparam logic [STATE_W-1:0] ST_CLOSED      = 4'd0;
   localparam logic [STATE_W-1:0] ST_ASSIGNED    = 4'd1;
   localparam logic [STATE_W-1:0] ST_ID_SET      = 4'd2;
   localparam logic [STATE_W-1:0] ST_FREQ_SET    = 4'd3;
   localparam logic [STATE_W-1:0] ST_PERIOD_SET  = 4'd4;
   localparam logic [STATE_W-1:0] ST_TIMEOUT_SET = 4'd5;
   localparam logic [STATE_W-1:0] ST_OPENED      = 4'd6;
   localparam logic [STATE_W-1:0] ST_SEARCHING   = 4'd7;
   localparam logic [STATE_W-1:0] ST_TRACKING    = 4'd8;
   localparam logic [STATE_W-1:0] ST_SEARCH_TO   = 4'd9;
   localparam logic [STATE_W-1:0] ST_UNASSIGNED  = 4'd10;

   // notices
   localparam logic [NOTICE_W-1:0] NOTE_NONE       = 2'd0;
   localparam logic [NOTICE_W-1:0] NOTE_SEARCH_TO  = 2'd1;
   localparam logic [NOTICE_W-1:0] NOTE_FOUND      = 2'd2;
   localparam logic [NOTICE_W-1:0] NOTE_UNASSIGNED = 2'd3;

   // decoded operations
   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_START     = 4'd1;
   localparam logic [OP_W-1:0] OP_CLOSE     = 4'd2;
   localparam logic [OP_W-1:0] OP_OK        = 4'd3;
   localparam logic [OP_W-1:0] OP_SEARCH_TO = 4'd4;
   localparam logic [OP_W-1:0] OP_GO_SEARCH = 4'd5;
   localparam logic [OP_W-1:0] OP_CLOSED    = 4'd6;
   localparam logic [OP_W-1:0] OP_ACK_DONE  = 4'd7;
   localparam logic [OP_W-1:0] OP_ACK_FAIL  = 4'd8;
   localparam logic [OP_W-1:0] OP_BROADCAST = 4'd9;
   localparam logic [OP_W-1:0] OP_ID_FOUND  = 4'd10;
   localparam logic [OP_W-1:0] OP_QUEUE_ACK = 4'd11;
   localparam logic [OP_W-1:0] OP_TICK      = 4'd12;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [RID_W-1:0]     rid;
      logic [PAYLOAD_W-1:0] arg;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHAN_W-1:0]    channel;
      logic [PAYLOAD_W-1:0] arg;
      logic [CTYPE_W-1:0]   ctype;
      logic [STATE_W-1:0]   state;
      logic [NOTICE_W-1:0]  notice;
      logic                 mismatch;
      logic                 last;
   } res_type;

endpackage

/* rtl/rcss_front.sv */
// rcss_front: request intake, decodes kind and event code into one operation
// depends on rcss_pkg; feeds rcss_cmdq
module rcss_front
   import rcss_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [EVENT_W-1:0]   req_event_code,
   input  logic [RID_W-1:0]     req_response_id,
   input  logic [DEVICE_W-1:0]  req_found_device,
   input  logic [PAYLOAD_W-1:0] req_ack_payload,
   input  logic                 push_ready,
   output logic                 push_valid,
   output entry_type            push_ent
);

   logic [OP_W-1:0] op;

   always_comb begin
      op = OP_NONE;
      unique case (req_kind)
         KIND_START:     op = OP_START;
         KIND_CLOSE:     op = OP_CLOSE;
         KIND_EVENT: begin
            unique case (req_event_code)
               EV_OK:             op = OP_OK;
               EV_SEARCH_TIMEOUT: op = OP_SEARCH_TO;
               EV_GO_SEARCH:      op = OP_GO_SEARCH;
               EV_CLOSED:         op = OP_CLOSED;
               EV_ACK_DONE:       op = OP_ACK_DONE;
               EV_ACK_FAIL:       op = OP_ACK_FAIL;
               default:           op = OP_NONE;
            endcase
         end
         KIND_BROADCAST: op = OP_BROADCAST;
         KIND_ID_FOUND:  op = OP_ID_FOUND;
         KIND_QUEUE_ACK: op = OP_QUEUE_ACK;
         KIND_TICK:      op = OP_TICK;
         default:        op = OP_NONE;
      endcase
   end

   // found device and payload never travel together, so one arg field serves both
   assign push_ent.op  = op;
   assign push_ent.rid = req_response_id;
   assign push_ent.arg = (req_kind == KIND_ID_FOUND) ? PAYLOAD_W'(req_found_device)
                                                     : req_ack_payload;

   assign push_valid = req_valid;
   assign req_stall  = !push_ready;

endmodule

/* rtl/rcss_cmdq.sv */
// rcss_cmdq: short queue of decoded requests between front and back
// depends on rcss_pkg
module rcss_cmdq
   import rcss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_ent,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_ent
);

   entry_type            ent_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   cnt_ff, cnt_in;
   logic                 push, pop;

   assign push_ready = (cnt_ff != CMDQ_CW'(CMDQ_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_ent    = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

/* rtl/rcss_back.sv */
// rcss_back: executes decoded requests, holds channel state, config registers,
// the ack payload store with its timer, and the two-slot response buffer; uses rcss_pkg
module rcss_back
   import rcss_pkg::*;
#(
   parameter int ACK_QUEUE_LIMIT      = ACK_QUEUE_LIMIT_DEF,
   parameter int SEARCH_TIMEOUT_VALUE = SEARCH_TIMEOUT_VALUE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  entry_type            q_ent,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output res_type              rsp
);

   localparam int STORE_DEPTH = ACK_QUEUE_LIMIT + 1;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW          = $clog2(STORE_DEPTH + 1);

   // configuration
   logic [CHAN_W-1:0]    chan_ff;
   logic [DEVICE_W-1:0]  preset_ff;
   logic [CTYPE_W-1:0]   stype_ff;
   logic [PERIOD_W-1:0]  period_ff;
   logic                 master_ff;
   logic [TICKS_W-1:0]   ticks_ff;

   // channel and ack queue state
   logic [STATE_W-1:0]   state_ff, state_in;
   logic [DEVICE_W-1:0]  dev_ff, dev_in;
   logic [PAYLOAD_W-1:0] store_ff [STORE_DEPTH];
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 inflight_ff, inflight_in;
   logic                 running_ff, running_in;
   logic [TICKS_W-1:0]   timer_ff, timer_in;

   // response buffer
   res_type              slot0_ff, slot0_in;
   res_type              slot1_ff, slot1_in;
   logic [1:0]           ocnt_ff, ocnt_in;

   res_type              res0, res1;
   logic                 two_res;
   logic [NOTICE_W-1:0]  notice;
   logic                 mis;
   logic                 wr_en;
   logic [AW-1:0]        wr_idx;
   logic [CW:0]          tail_sum;
   logic [AW-1:0]        head_next;
   logic                 have_ack;
   logic                 send_ok;
   logic [PAYLOAD_W-1:0] head_payload;
   logic                 take, free, pop;

   function automatic res_type mk_cmd(input logic [CMD_W-1:0]     cmd,
                                      input logic [PAYLOAD_W-1:0] arg,
                                      input logic [CTYPE_W-1:0]   ctype,
                                      input logic [CHAN_W-1:0]    chan);
      res_type r;
      r          = '0;
      r.command  = cmd;
      r.channel  = (cmd != CMD_NONE) ? chan : '0;
      r.arg      = arg;
      r.ctype    = ctype;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= '0;
         preset_ff <= '0;
         stype_ff  <= '0;
         period_ff <= PERIOD_RESET;
         master_ff <= 1'b0;
         ticks_ff  <= ACK_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CHANNEL_NUMBER:    chan_ff   <= csr_data[CHAN_W-1:0];
            REG_PRESET_DEVICE:     preset_ff <= csr_data[DEVICE_W-1:0];
            REG_SENSOR_TYPE:       stype_ff  <= csr_data[CTYPE_W-1:0];
            REG_CHANNEL_PERIOD:    period_ff <= csr_data[PERIOD_W-1:0];
            REG_MASTER_MODE:       master_ff <= csr_data[0];
            REG_ACK_TIMEOUT_TICKS: ticks_ff  <= csr_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   assign have_ack     = (count_ff != '0);
   assign send_ok      = !inflight_ff && have_ack;
   assign head_payload = store_ff[head_ff];
   assign head_next    = (head_ff == AW'(STORE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum     = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign wr_idx       = (tail_sum >= (CW + 1)'(STORE_DEPTH))
                         ? AW'(tail_sum - (CW + 1)'(STORE_DEPTH)) : AW'(tail_sum);

   always_comb begin
      state_in    = state_ff;
      dev_in      = dev_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      inflight_in = inflight_ff;
      running_in  = running_ff;
      timer_in    = timer_ff;
      res0        = mk_cmd(CMD_NONE, '0, '0, chan_ff);
      res1        = mk_cmd(CMD_NONE, '0, '0, chan_ff);
      two_res     = 1'b0;
      notice      = NOTE_NONE;
      mis         = 1'b0;
      wr_en       = 1'b0;

      unique case (q_ent.op)
         OP_START: begin
            res0     = mk_cmd(CMD_ASSIGN, master_ff ? MASTER_CHAN_TYPE : '0, '0, chan_ff);
            dev_in   = preset_ff;
            state_in = ST_ASSIGNED;
         end
         OP_CLOSE: begin
            state_in = ST_CLOSED;
            count_in = '0;
            head_in  = '0;
            res0     = mk_cmd(CMD_CLOSE, '0, '0, chan_ff);
         end
         OP_OK: begin
            // a wrong response id is flagged, the setup still moves on
            unique case (state_ff)
               ST_ASSIGNED: begin
                  mis      = (q_ent.rid != RID_ASSIGN);
                  res0     = mk_cmd(CMD_SET_ID, PAYLOAD_W'(dev_ff), stype_ff, chan_ff);
                  state_in = ST_ID_SET;
               end
               ST_ID_SET: begin
                  mis      = (q_ent.rid != RID_ID);
                  res0     = mk_cmd(CMD_FREQ, '0, '0, chan_ff);
                  state_in = ST_FREQ_SET;
               end
               ST_FREQ_SET: begin
                  mis      = (q_ent.rid != RID_FREQ);
                  res0     = mk_cmd(CMD_PERIOD, PAYLOAD_W'(period_ff), '0, chan_ff);
                  state_in = ST_PERIOD_SET;
               end
               ST_PERIOD_SET: begin
                  mis = (q_ent.rid != RID_PERIOD);
                  if (master_ff) begin
                     res0     = mk_cmd(CMD_OPEN, '0, '0, chan_ff);
                     state_in = ST_OPENED;
                  end else begin
                     res0     = mk_cmd(CMD_SEARCH_TO, PAYLOAD_W'(SEARCH_TIMEOUT_VALUE),
                                       '0, chan_ff);
                     state_in = ST_TIMEOUT_SET;
                  end
               end
               ST_TIMEOUT_SET: begin
                  mis      = (q_ent.rid != RID_TIMEOUT);
                  res0     = mk_cmd(CMD_OPEN, '0, '0, chan_ff);
                  state_in = ST_OPENED;
               end
               ST_OPENED: begin
                  mis      = (q_ent.rid != RID_OPEN);
                  state_in = ST_SEARCHING;
               end
               ST_CLOSED:   mis = (q_ent.rid != RID_CLOSE);
               ST_TRACKING: mis = (q_ent.rid != RID_TIMEOUT);
               ST_UNASSIGNED: begin
                  mis    = (q_ent.rid != RID_UNASSIGN);
                  notice = NOTE_UNASSIGNED;
               end
               default: ;
            endcase
         end
         OP_SEARCH_TO: begin
            notice   = NOTE_SEARCH_TO;
            res0     = mk_cmd(CMD_UNASSIGN, '0, '0, chan_ff);
            state_in = ST_UNASSIGNED;
         end
         OP_GO_SEARCH: state_in = ST_SEARCHING;
         OP_CLOSED: begin
            if (state_ff != ST_UNASSIGNED) begin
               res0     = mk_cmd(CMD_UNASSIGN, '0, '0, chan_ff);
               state_in = ST_UNASSIGNED;
            end
         end
         OP_ACK_DONE: begin
            running_in  = 1'b0;
            inflight_in = 1'b0;
            if (have_ack) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
         end
         OP_ACK_FAIL: begin
            running_in  = 1'b0;
            inflight_in = 1'b0;
            if (have_ack) begin
               inflight_in = 1'b1;
               running_in  = 1'b1;
               timer_in    = ticks_ff;
               res0        = mk_cmd(CMD_SEND_ACK, head_payload, '0, chan_ff);
            end
         end
         OP_BROADCAST: begin
            if (send_ok) begin
               inflight_in = 1'b1;
               running_in  = 1'b1;
               timer_in    = ticks_ff;
               res0        = mk_cmd(CMD_SEND_ACK, head_payload, '0, chan_ff);
            end
            if (state_ff == ST_SEARCHING) begin
               if (send_ok) begin
                  res1    = mk_cmd(CMD_REQUEST_ID, '0, '0, chan_ff);
                  two_res = 1'b1;
               end else begin
                  res0 = mk_cmd(CMD_REQUEST_ID, '0, '0, chan_ff);
               end
               state_in = ST_TRACKING;
            end
         end
         OP_ID_FOUND: begin
            dev_in   = q_ent.arg[DEVICE_W-1:0];
            state_in = ST_TRACKING;
            notice   = NOTE_FOUND;
            res0     = mk_cmd(CMD_INFINITE_TO, '0, '0, chan_ff);
         end
         OP_QUEUE_ACK: begin
            // full store: the new payload overwrites the oldest entry
            wr_en = 1'b1;
            if (count_ff == CW'(STORE_DEPTH)) begin
               head_in = head_next;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_TICK: begin
            if (running_ff) begin
               if (timer_ff <= TICKS_W'(1)) begin
                  timer_in    = '0;
                  running_in  = 1'b0;
                  inflight_in = 1'b0;
                  if (have_ack) begin
                     inflight_in = 1'b1;
                     running_in  = 1'b1;
                     timer_in    = ticks_ff;
                     res0        = mk_cmd(CMD_SEND_ACK, head_payload, '0, chan_ff);
                  end
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase

      res0.state    = state_in;
      res0.notice   = two_res ? NOTE_NONE : notice;
      res0.mismatch = two_res ? 1'b0 : mis;
      res0.last     = !two_res;
      res1.state    = state_in;
      res1.last     = 1'b1;
   end

   // response buffer: a new request is taken once the buffer drains this cycle
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign rsp       = slot0_ff;
   assign take      = rsp_valid && !rsp_stall;
   assign free      = (ocnt_ff == 2'd0) || ((ocnt_ff == 2'd1) && take);
   assign q_ready   = free;
   assign pop       = q_valid && free;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      ocnt_in  = ocnt_ff;
      if (pop) begin
         slot0_in = res0;
         slot1_in = res1;
         ocnt_in  = two_res ? 2'd2 : 2'd1;
      end else if (take) begin
         slot0_in = slot1_ff;
         ocnt_in  = ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLOSED;
         dev_ff      <= '0;
         head_ff     <= '0;
         count_ff    <= '0;
         inflight_ff <= 1'b0;
         running_ff  <= 1'b0;
         timer_ff    <= '0;
         ocnt_ff     <= 2'd0;
      end else begin
         if (pop) begin
            state_ff    <= state_in;
            dev_ff      <= dev_in;
            head_ff     <= head_in;
            count_ff    <= count_in;
            inflight_ff <= inflight_in;
            running_ff  <= running_in;
            timer_ff    <= timer_in;
         end
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (pop && wr_en) begin
         store_ff[wr_idx] <= q_ent.arg;
      end
   end

endmodule

/* rtl/radio_channel_setup_sequencer_core.sv */
// radio_channel_setup_sequencer_core: top level of the channel setup sequencer
// depends on rcss_pkg, rcss_front, rcss_cmdq and rcss_back
//
// Usage:
//   req_*  request channel (valid/stall): one event per request, kind selects
//          start, close, channel event, broadcast, id found, queue ack or tick.
//   rsp_*  response channel (valid/stall): one or two responses per request,
//          rsp_last marks the final one. A broadcast that both sends a queued
//          ack and requests the sensor id gives two (send ack first).
//   csr_*  register writes (valid/ready), csr_ready is always high; write only
//          while no request is outstanding.
// Path: the first response of a request passes the front queue entry, then the
//   response register; it waits in the queue while the response buffer is busy.
// Throughput: one request per cycle for single-response requests while rsp_stall
//   is low; a double response holds the next request until the two-slot buffer drains.
// Reset: synchronous; channel closed, device and ack queue empty, timer
//   stopped, registers at their defaults. No clearing pass is needed.
// A stalled response holds its payload; up to two decoded requests wait in
//   the front queue before req_stall rises.
module radio_channel_setup_sequencer_core
   import rcss_pkg::*;
#(
   parameter int ACK_QUEUE_LIMIT      = ACK_QUEUE_LIMIT_DEF,
   parameter int SEARCH_TIMEOUT_VALUE = SEARCH_TIMEOUT_VALUE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [EVENT_W-1:0]   req_event_code,
   input  logic [RID_W-1:0]     req_response_id,
   input  logic [DEVICE_W-1:0]  req_found_device,
   input  logic [PAYLOAD_W-1:0] req_ack_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CMD_W-1:0]     rsp_command,
   output logic [CHAN_W-1:0]    rsp_command_channel,
   output logic [PAYLOAD_W-1:0] rsp_command_arg,
   output logic [CTYPE_W-1:0]   rsp_command_type,
   output logic [STATE_W-1:0]   rsp_channel_state,
   output logic [NOTICE_W-1:0]  rsp_notice,
   output logic                 rsp_id_mismatch,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   entry_type push_ent, pop_ent;
   logic      push_valid, push_ready;
   logic      pop_valid, pop_ready;
   res_type   rsp;

   assign csr_ready = 1'b1;

   rcss_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_event_code   (req_event_code),
      .req_response_id  (req_response_id),
      .req_found_device (req_found_device),
      .req_ack_payload  (req_ack_payload),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_ent         (push_ent)
   );

   rcss_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ent   (push_ent),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ent    (pop_ent)
   );

   rcss_back #(
      .ACK_QUEUE_LIMIT      (ACK_QUEUE_LIMIT),
      .SEARCH_TIMEOUT_VALUE (SEARCH_TIMEOUT_VALUE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_ent     (pop_ent),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_command         = rsp.command;
   assign rsp_command_channel = rsp.channel;
   assign rsp_command_arg     = rsp.arg;
   assign rsp_command_type    = rsp.ctype;
   assign rsp_channel_state   = rsp.state;
   assign rsp_notice          = rsp.notice;
   assign rsp_id_mismatch     = rsp.mismatch;
   assign rsp_last            = rsp.last;

endmodule

/* rtl/rcss_checker.sv */
// rcss_checker: port-level assertions for radio_channel_setup_sequencer_core
// depends on rcss_pkg; bound to the top level at the end of this file
module rcss_checker
   import rcss_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CMD_W-1:0]     rsp_command,
   input logic [CHAN_W-1:0]    rsp_command_channel,
   input logic [PAYLOAD_W-1:0] rsp_command_arg,
   input logic [STATE_W-1:0]   rsp_channel_state,
   input logic [NOTICE_W-1:0]  rsp_notice,
   input logic                 rsp_id_mismatch,
   input logic                 rsp_last
);

   // nothing left over from before reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command)
                                 && $stable(rsp_command_arg) && $stable(rsp_last))
      else $error("stalled response changed");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_NONE |->
         rsp_command_channel == '0 && rsp_command_arg == '0)
      else $error("empty command carries channel or arg");

   // only a broadcast splits into two, ack send first with no flags
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
         rsp_command == CMD_SEND_ACK && rsp_notice == NOTE_NONE && !rsp_id_mismatch
         && rsp_channel_state == ST_TRACKING)
      else $error("bad first response of a pair");

   a_set_id_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_SET_ID |-> rsp_channel_state == ST_ID_SET)
      else $error("set id outside id set state");

endmodule

bind radio_channel_setup_sequencer_core rcss_checker u_rcss_checker (.*);
